@@ hdl/rau_pkg.sv @@
package rau_pkg;

  localparam int unsigned WORD = 64;
  localparam int unsigned CNT_W = $clog2(WORD);

  typedef enum logic [2:0] {
    OP_NORM  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_EQ    = 3'd5,
    OP_LESS  = 3'd6,
    OP_NONE  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_X,
    PH_Y,
    PH_R
  } phase_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_RED,
    S_GCD,
    S_DIVM,
    S_DIVD,
    S_FIT,
    S_MUL1,
    S_MUL2,
    S_AGCD,
    S_ADX,
    S_ADY,
    S_AM1,
    S_AM2,
    S_AM3,
    S_ASUM,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] first_num;
    logic signed [31:0] first_den;
    logic signed [31:0] second_num;
    logic signed [31:0] second_den;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_num;
    logic [30:0]        result_den;
    logic               compare_true;
    logic [1:0]         status;
  } out_word_t;

  typedef struct packed {
    logic            neg;
    logic [WORD-1:0] mag;
    logic [WORD-1:0] den;
  } frac_t;

endpackage

@@ hdl/rau_gcd.sv @@
module rau_gcd
  import rau_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [WORD-1:0] a_i,
  input  logic [WORD-1:0] b_i,
  output logic            done_o,
  output logic [WORD-1:0] gcd_o
);

  logic             busy_q, busy_d;
  logic [WORD-1:0]  a_q, a_d, b_q, b_d;
  logic [CNT_W-1:0] k_q, k_d;

  assign done_o = busy_q && a_q[0] && b_q[0] && (a_q == b_q);
  assign gcd_o  = a_q << k_q;

  always_comb begin
    busy_d = busy_q;
    a_d    = a_q;
    b_d    = b_q;
    k_d    = k_q;
    if (start_i) begin
      busy_d = 1'b1;
      a_d    = a_i;
      b_d    = b_i;
      k_d    = '0;
    end else if (busy_q) begin
      if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + CNT_W'(1);
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_q == b_q) begin
        busy_d = 1'b0;
      end else if (a_q > b_q) begin
        a_d = a_q - b_q;
      end else begin
        b_d = b_q - a_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    k_q <= k_d;
  end

endmodule

@@ hdl/rau_div.sv @@
module rau_div
  import rau_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [WORD-1:0] num_i,
  input  logic [WORD-1:0] den_i,
  output logic            done_o,
  output logic [WORD-1:0] quo_o
);

  logic             busy_q, busy_d, done_q, done_d;
  logic [WORD-1:0]  rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [WORD:0]    trial;
  logic             fits;

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign trial  = {rem_q, quo_q[WORD-1]};
  assign fits   = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      cnt_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? WORD'(trial - {1'b0, den_q}) : trial[WORD-1:0];
      quo_d = {quo_q[WORD-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(WORD - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    cnt_q <= cnt_d;
  end

endmodule

@@ hdl/rational_arithmetic_unit.sv @@
// Rational arithmetic unit: one operation on two fractions per input word.
// Input channel in_valid_i / in_stall_o carries the opcode and the two
// numerator/denominator pairs; output channel out_valid_o / out_stall_i
// carries one result word per input word (reduced fraction, compare flag,
// status). One word is processed at a time; in_stall_o is high from
// acceptance until the result is loaded into the output register.
// An unused opcode or a zero denominator goes from the check state straight
// to the done state; a zero numerator is normalized without a GCD. Each
// other reduction costs one binary GCD (one compare/subtract or shift per
// cycle) plus two restoring divisions; add, subtract and less-than add a GCD
// of the denominators and two more divisions. The 32x32 multiplier is
// combinational; each product is registered in its own state.
// The output register frees the core as soon as a result is loaded; while
// the receiver stalls, a finished result waits and the next word waits in
// the done state. Reset clears the sequencer and out_valid_o.
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam logic [WORD-1:0] LIM = WORD'(1) << (VALUE_WIDTH - 1);
  localparam int unsigned SH = 32 - VALUE_WIDTH;

  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  logic            out_valid_q, out_valid_d;
  out_word_t       out_q, out_d;
  op_e             op_q, op_d;
  logic [WORD-1:0] n1_q, n1_d, d1_q, d1_d, n2_q, n2_d, d2_q, d2_d;
  frac_t           w_q, w_d, x_q, x_d, y_q, y_d;
  logic [WORD-1:0] g_q, g_d, t1_q, t1_d, t2_q, t2_d, pa_q, pa_d, pb_q, pb_d;
  logic [1:0]      status_q, status_d;
  logic            cmp_q, cmp_d, give_q, give_d;

  logic            gcd_start, gcd_done, div_start, div_done;
  logic [WORD-1:0] gcd_a, gcd_b, gcd_g, div_n, div_d, div_q;
  logic [31:0]     mul_a, mul_b;
  logic [WORD-1:0] mul_p;
  logic            fit, nb;
  logic [WORD-1:0] res_num;

  function automatic logic [WORD-1:0] sext(input logic [31:0] v);
    logic signed [31:0] t;
    t = $signed(v << SH) >>> SH;
    return WORD'(t);
  endfunction

  function automatic frac_t make_frac(input logic [WORD-1:0] n, input logic [WORD-1:0] d);
    frac_t f;
    f.neg = n[WORD-1] ^ d[WORD-1];
    f.mag = n[WORD-1] ? -n : n;
    f.den = d[WORD-1] ? -d : d;
    return f;
  endfunction

  rau_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (gcd_a),
    .b_i     (gcd_b),
    .done_o  (gcd_done),
    .gcd_o   (gcd_g)
  );

  rau_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_n),
    .den_i   (div_d),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  assign mul_p       = WORD'(mul_a) * WORD'(mul_b);
  assign fit         = (w_q.den <= LIM - WORD'(1)) &&
                       (w_q.neg ? (w_q.mag <= LIM) : (w_q.mag <= LIM - WORD'(1)));
  assign nb          = (op_q == OP_ADD) ? y_q.neg : !y_q.neg;
  assign res_num     = w_q.neg ? -w_q.mag : w_q.mag;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    op_d        = op_q;
    n1_d        = n1_q;
    d1_d        = d1_q;
    n2_d        = n2_q;
    d2_d        = d2_q;
    w_d         = w_q;
    x_d         = x_q;
    y_d         = y_q;
    g_d         = g_q;
    t1_d        = t1_q;
    t2_d        = t2_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    status_d    = status_q;
    cmp_d       = cmp_q;
    give_d      = give_q;
    gcd_start   = 1'b0;
    gcd_a       = w_q.mag;
    gcd_b       = w_q.den;
    div_start   = 1'b0;
    div_n       = w_q.mag;
    div_d       = g_q;
    mul_a       = x_q.mag[31:0];
    mul_b       = y_q.mag[31:0];
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = op_e'(in_word_i.operation);
          n1_d     = sext(in_word_i.first_num);
          d1_d     = sext(in_word_i.first_den);
          n2_d     = sext(in_word_i.second_num);
          d2_d     = sext(in_word_i.second_den);
          status_d = ST_OK;
          cmp_d    = 1'b0;
          give_d   = 1'b0;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (op_q == OP_NONE) begin
          state_d = S_DONE;
        end else if (d1_q == '0 || (op_q != OP_NORM && d2_q == '0)) begin
          status_d = ST_ZERO_DEN;
          state_d  = S_DONE;
        end else begin
          w_d     = make_frac(n1_q, d1_q);
          phase_d = PH_X;
          state_d = S_RED;
        end
      end
      S_RED: begin
        if (w_q.mag == '0) begin
          w_d.neg = 1'b0;
          w_d.den = WORD'(1);
          state_d = S_FIT;
        end else begin
          gcd_start = 1'b1;
          state_d   = S_GCD;
        end
      end
      S_GCD: begin
        if (gcd_done) begin
          g_d       = gcd_g;
          div_start = 1'b1;
          div_d     = gcd_g;
          state_d   = S_DIVM;
        end
      end
      S_DIVM: begin
        if (div_done) begin
          w_d.mag   = div_q;
          div_start = 1'b1;
          div_n     = w_q.den;
          state_d   = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_done) begin
          w_d.den = div_q;
          state_d = S_FIT;
        end
      end
      S_FIT: begin
        if (!fit) begin
          status_d = ST_OVERFLOW;
          state_d  = S_DONE;
        end else begin
          case (phase_q)
            PH_X: begin
              x_d = w_q;
              if (op_q == OP_NORM) begin
                give_d  = 1'b1;
                state_d = S_DONE;
              end else begin
                w_d     = make_frac(n2_q, d2_q);
                phase_d = PH_Y;
                state_d = S_RED;
              end
            end
            PH_Y: begin
              y_d = w_q;
              case (op_q)
                OP_ADD, OP_SUB, OP_LESS: begin
                  gcd_start = 1'b1;
                  gcd_a     = x_q.den;
                  gcd_b     = w_q.den;
                  state_d   = S_AGCD;
                end
                OP_MUL: begin
                  state_d = S_MUL1;
                end
                OP_DIV: begin
                  if (w_q.mag == '0) begin
                    status_d = ST_DIV_ZERO;
                    state_d  = S_DONE;
                  end else begin
                    state_d = S_MUL1;
                  end
                end
                OP_EQ: begin
                  cmp_d   = (x_q == w_q);
                  state_d = S_DONE;
                end
                default: begin
                  state_d = S_DONE;
                end
              endcase
            end
            default: begin
              give_d  = 1'b1;
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_MUL1: begin
        mul_b   = (op_q == OP_DIV) ? y_q.den[31:0] : y_q.mag[31:0];
        w_d.neg = x_q.neg ^ y_q.neg;
        w_d.mag = mul_p;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        mul_a   = x_q.den[31:0];
        mul_b   = (op_q == OP_DIV) ? y_q.mag[31:0] : y_q.den[31:0];
        w_d.den = mul_p;
        phase_d = PH_R;
        state_d = S_RED;
      end
      S_AGCD: begin
        if (gcd_done) begin
          g_d       = gcd_g;
          div_start = 1'b1;
          div_n     = x_q.den;
          div_d     = gcd_g;
          state_d   = S_ADX;
        end
      end
      S_ADX: begin
        if (div_done) begin
          t1_d      = div_q;
          div_start = 1'b1;
          div_n     = y_q.den;
          state_d   = S_ADY;
        end
      end
      S_ADY: begin
        if (div_done) begin
          t2_d    = div_q;
          state_d = S_AM1;
        end
      end
      S_AM1: begin
        mul_b   = t2_q[31:0];
        pa_d    = mul_p;
        state_d = S_AM2;
      end
      S_AM2: begin
        mul_a   = y_q.mag[31:0];
        mul_b   = t1_q[31:0];
        pb_d    = mul_p;
        state_d = S_AM3;
      end
      S_AM3: begin
        mul_a   = t1_q[31:0];
        mul_b   = y_q.den[31:0];
        w_d.den = mul_p;
        state_d = S_ASUM;
      end
      S_ASUM: begin
        if (x_q.neg == nb) begin
          w_d.neg = x_q.neg;
          w_d.mag = pa_q + pb_q;
        end else if (pa_q >= pb_q) begin
          w_d.neg = x_q.neg;
          w_d.mag = pa_q - pb_q;
        end else begin
          w_d.neg = nb;
          w_d.mag = pb_q - pa_q;
        end
        if (op_q == OP_LESS) begin
          cmp_d   = (x_q.neg == nb) ? x_q.neg : ((pa_q >= pb_q) ? (x_q.neg && pa_q != pb_q) : nb);
          state_d = S_DONE;
        end else begin
          phase_d = PH_R;
          state_d = S_RED;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (status_q != ST_OK || !give_q) begin
            out_d.result_num = '0;
            out_d.result_den = '0;
          end else begin
            out_d.result_num = res_num[31:0];
            out_d.result_den = w_q.den[30:0];
          end
          out_d.compare_true = (status_q == ST_OK) ? cmp_q : 1'b0;
          out_d.status       = status_q;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q  <= phase_d;
    out_q    <= out_d;
    op_q     <= op_d;
    n1_q     <= n1_d;
    d1_q     <= d1_d;
    n2_q     <= n2_d;
    d2_q     <= d2_d;
    w_q      <= w_d;
    x_q      <= x_d;
    y_q      <= y_d;
    g_q      <= g_d;
    t1_q     <= t1_d;
    t2_q     <= t2_d;
    pa_q     <= pa_d;
    pb_q     <= pb_d;
    status_q <= status_d;
    cmp_q    <= cmp_d;
    give_q   <= give_d;
  end

endmodule

@@ tb/sv/tb_rational_arithmetic_unit.sv @@
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  localparam int unsigned W = 32;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned RANDOM_PER_PHASE = 282;

  typedef struct {
    bit      neg;
    longint unsigned mag;
    longint unsigned den;
  } ratio_t;

  class rational_scoreboard;
    out_word_t pending_q[$];
    int unsigned errors;
    int unsigned checked;

    function longint unsigned abs64(longint x);
      return (x < 0) ? (64'd0 - x) : x;
    endfunction

    function longint unsigned gcd64(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return a;
    endfunction

    function bit reduce_fits(inout ratio_t f);
      longint unsigned lim;
      longint unsigned g;
      lim = 64'd1 << (W - 1);
      if (f.mag == 0) begin
        f.neg = 0;
        f.den = 1;
      end else begin
        g = gcd64(f.mag, f.den);
        f.mag = f.mag / g;
        f.den = f.den / g;
      end
      if (f.den > lim - 1) return 0;
      if (f.neg) return f.mag <= lim;
      return f.mag <= lim - 1;
    endfunction

    function ratio_t to_ratio(logic signed [31:0] n, logic signed [31:0] d);
      ratio_t f;
      longint ln;
      longint ld;
      ln = n;
      ld = d;
      f.neg = (ln < 0) != (ld < 0);
      f.mag = abs64(ln);
      f.den = abs64(ld);
      return f;
    endfunction

    function ratio_t sum_ratio(ratio_t x, ratio_t y, bit sub);
      ratio_t r;
      longint unsigned g;
      longint unsigned a;
      longint unsigned b;
      bit nb;
      g = gcd64(x.den, y.den);
      a = x.mag * (y.den / g);
      b = y.mag * (x.den / g);
      nb = sub ? !y.neg : y.neg;
      if (x.neg == nb) begin
        r.neg = x.neg;
        r.mag = a + b;
      end else if (a >= b) begin
        r.neg = x.neg;
        r.mag = a - b;
      end else begin
        r.neg = nb;
        r.mag = b - a;
      end
      r.den = (x.den / g) * y.den;
      return r;
    endfunction

    function out_word_t compute(in_word_t w);
      ratio_t x;
      ratio_t y;
      ratio_t r;
      ratio_t t;
      logic [1:0] st;
      bit cmp;
      bit give;
      longint unsigned nv;
      out_word_t o;
      st = ST_OK;
      cmp = 0;
      give = 0;
      r.neg = 0;
      r.mag = 0;
      r.den = 0;
      if (w.operation == OP_NONE) begin
      end else if (w.first_den == 0 || (w.operation != OP_NORM && w.second_den == 0)) begin
        st = ST_ZERO_DEN;
      end else begin
        x = to_ratio(w.first_num, w.first_den);
        if (!reduce_fits(x)) begin
          st = ST_OVERFLOW;
        end else if (w.operation == OP_NORM) begin
          r = x;
          give = 1;
        end else begin
          y = to_ratio(w.second_num, w.second_den);
          if (!reduce_fits(y)) begin
            st = ST_OVERFLOW;
          end else begin
            case (w.operation)
              OP_ADD, OP_SUB: begin
                r = sum_ratio(x, y, w.operation == OP_SUB);
                give = 1;
              end
              OP_MUL: begin
                r.neg = x.neg != y.neg;
                r.mag = x.mag * y.mag;
                r.den = x.den * y.den;
                give = 1;
              end
              OP_DIV: begin
                if (y.mag == 0) begin
                  st = ST_DIV_ZERO;
                end else begin
                  r.neg = x.neg != y.neg;
                  r.mag = x.mag * y.den;
                  r.den = x.den * y.mag;
                  give = 1;
                end
              end
              OP_EQ: cmp = (x.neg == y.neg) && (x.mag == y.mag) && (x.den == y.den);
              default: begin
                t = sum_ratio(x, y, 1);
                cmp = t.neg && (t.mag != 0);
              end
            endcase
          end
        end
      end
      if (give && !reduce_fits(r)) st = ST_OVERFLOW;
      o = '0;
      if (st == ST_OK && give) begin
        nv = r.neg ? (64'd0 - r.mag) : r.mag;
        o.result_num = nv[31:0];
        o.result_den = r.den[30:0];
      end
      o.compare_true = (st == ST_OK) ? cmp : 1'b0;
      o.status = st;
      return o;
    endfunction

    function void note_input(in_word_t w);
      pending_q.push_back(compute(w));
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp;
      checked++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result num=%0d den=%0d cmp=%0b st=%0d", $time,
                 got.result_num, got.result_den, got.compare_true, got.status);
        return;
      end
      exp = pending_q.pop_front();
      if (got !== exp) begin
        errors++;
        $display("%0t: mismatch exp num=%0d den=%0d cmp=%0b st=%0d", $time,
                 exp.result_num, exp.result_den, exp.compare_true, exp.status);
        $display("%0t:          got num=%0d den=%0d cmp=%0b st=%0d", $time,
                 got.result_num, got.result_den, got.compare_true, got.status);
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  rational_arithmetic_unit u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_word_i(in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o(out_word_o)
  );

  rational_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned idle_cycles;
  int unsigned sent;
  bit          out_valid_s;
  bit          out_stall_s;
  out_word_t   out_word_s;
  bit          in_acc;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_valid_s <= out_valid_o;
    out_stall_s <= out_stall_i;
    out_word_s  <= out_word_o;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_s && !out_stall_s) sb.check_result(out_word_s);
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (in_acc || (rst_ni && out_valid_s && !out_stall_s)) idle_cycles = 0;
    else idle_cycles++;
    in_acc = 0;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_rational_arithmetic_unit: FAIL");
      $finish;
    end
  end

  task automatic send_word(in_word_t w);
    bit s;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_word_i  <= w;
    forever begin
      @(negedge clk_i);
      s = in_stall_o;
      @(posedge clk_i);
      if (!s) break;
    end
    in_acc = 1;
    sb.note_input(w);
    sent++;
  endtask

  task automatic send_op(op_e op, int n1, int d1, int n2, int d2);
    in_word_t w;
    w.operation  = op;
    w.first_num  = n1;
    w.first_den  = d1;
    w.second_num = n2;
    w.second_den = d2;
    send_word(w);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    case ($urandom_range(0, 6))
      0, 1: v = $urandom_range(0, 40) - 20;
      2: v = $urandom;
      3: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h8000_0001;
          3: v = 32'h0000_0001;
          default: v = 32'hffff_ffff;
        endcase
      end
      4: begin
        v = 32'd1 << $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
      5: v = ($urandom_range(1, 50) * (32'd1 << $urandom_range(0, 24)));
      default: v = $urandom_range(0, 65535) - 32768;
    endcase
    return v;
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.operation = ($urandom_range(0, 49) == 0) ? 3'(OP_NONE) : 3'($urandom_range(0, 6));
    w.first_num  = rand_value();
    w.first_den  = rand_value();
    w.second_num = rand_value();
    w.second_den = rand_value();
    if ($urandom_range(0, 9) == 0)
      w = {3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom};
    return w;
  endfunction

  localparam int MIN = 32'h8000_0000;
  localparam int MAX = 32'h7fff_ffff;

  initial begin
    rst_ni = 0;
    in_valid_i = 0;
    in_word_i = '0;
    out_stall_i = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    idle_cycles = 0;
    sent = 0;
    in_acc = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_op(OP_NORM, 6, -4, 0, 0);
    send_op(OP_NORM, 0, -5, 0, 0);
    send_op(OP_NORM, 1, MIN, 0, 0);
    send_op(OP_NORM, MIN, 1, 3, 4);
    send_op(OP_NORM, MIN, -1, 3, 4);
    send_op(OP_NORM, MAX, MIN, 0, 0);
    send_op(OP_NORM, 5, 0, 1, 1);
    send_op(OP_ADD, 1, 2, 1, 3);
    send_op(OP_ADD, MAX, 1, 1, 1);
    send_op(OP_ADD, 1, 2, 1, 0);
    send_op(OP_SUB, 1, 2, 1, 2);
    send_op(OP_SUB, MIN, 1, 1, 1);
    send_op(OP_MUL, MAX, 1, MAX, 1);
    send_op(OP_MUL, -3, 7, 7, -3);
    send_op(OP_DIV, 2, 3, -4, 9);
    send_op(OP_DIV, 2, 3, 0, 9);
    send_op(OP_DIV, 1, MAX, MAX, 1);
    send_op(OP_EQ, 1, 2, 2, 4);
    send_op(OP_EQ, 1, 2, -1, 2);
    send_op(OP_LESS, -1, 3, 1, 3);
    send_op(OP_LESS, 2, 6, 1, 3);
    send_op(OP_LESS, 1, MIN, 1, 1);
    send_op(OP_NONE, 3, 4, 5, 6);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_word(rand_word());
      drain();
    end

    recv_stall_pct = 0;
    repeat (1000) @(posedge clk_i);
    $display("Sent %0d words (directed corner cases and random operands), checked %0d results",
             sent, sb.checked);
    $display("under four sender/receiver throttling mixes.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb_rational_arithmetic_unit: PASS");
    end else begin
      $display("%0d errors, %0d results missing", sb.errors, sb.pending_q.size());
      $display("tb_rational_arithmetic_unit: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/rau_pkg.sv
hdl/rau_gcd.sv
hdl/rau_div.sv
hdl/rational_arithmetic_unit.sv
tb/sv/tb_rational_arithmetic_unit.sv
